[src/itoa_pkg.sv]
// shared types, constants and the digit-to-ascii mapping for the radix converter
package itoa_pkg;

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int RADIX_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // register index carried in paddr[2]
  localparam logic REG_RADIX = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'd97;

  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < DIGIT_W'(10)) begin
      code = CHAR_ZERO + CHAR_W'(d);
    end else begin
      code = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return code;
  endfunction

endpackage

[src/integer_to_radix_ascii.sv]
// top level: apb radix register, request control and character output register
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_value (signed, WORD_BITS)
//   out      output     out_valid / out_ready  out_character (7), out_last_char (1)
//   cfg      input      psel/penable/pready    paddr, pwdata, pwrite -> prdata
//
// a request is converted one magnitude bit per cycle through the cell row (WORD_BITS
// bits), then the digit count is latched, then the digits leave one per cycle while
// the output is free; the minus sign goes out first, as soon as the output is free.
// rst_n is synchronous; it clears control state and sets the radix to ten.
// a stalled output holds the character; in_ready rises once the last one is loaded.
module integer_to_radix_ascii import itoa_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [WORD_BITS-1:0]   in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_last_char,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW    = $clog2(WORD_BITS+1);
  localparam int IDX_W = $clog2(WORD_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_PREP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic [RADIX_W-1:0]   radix_eff;
  logic [WORD_BITS-1:0] mag_r, mag_nxt;
  logic [CW-1:0]        step_r, step_nxt;
  logic                 neg_pending_r, neg_pending_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 in_fire;
  logic                 out_free;
  chain_ctl_t           ctl;
  logic [DIGIT_W-1:0]   rd_digit;
  logic [CW-1:0]        digit_count;

  assign pready = 1'b1;

  always_comb begin
    radix_nxt = radix_r;
    if (psel && penable && pwrite && paddr[2] == REG_RADIX) begin
      radix_nxt = pwdata[RADIX_W-1:0];
    end
    prdata = (paddr[2] == REG_RADIX) ? {{(32-RADIX_W){1'b0}}, radix_r} : '0;
  end

  // out-of-range radix values saturate
  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    mag_nxt         = mag_r;
    step_nxt        = step_r;
    neg_pending_nxt = neg_pending_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    ctl.clear       = 1'b0;
    ctl.shift       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // two's complement negate also gives the true magnitude of the most negative value
          mag_nxt         = in_value[WORD_BITS-1] ? (~in_value + WORD_BITS'(1)) : in_value;
          neg_pending_nxt = in_value[WORD_BITS-1];
          step_nxt        = CW'(WORD_BITS);
          ctl.clear       = 1'b1;
          state_nxt       = S_CONV;
        end
      end
      S_CONV: begin
        ctl.shift = 1'b1;
        mag_nxt   = {mag_r[WORD_BITS-2:0], 1'b0};
        step_nxt  = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        idx_nxt   = IDX_W'(digit_count - CW'(1));
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!neg_pending_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(rd_digit);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // the sign goes out first, as soon as the output is free; the digits wait for it
    if (state_r != S_IDLE && neg_pending_r && out_free) begin
      out_valid_nxt   = 1'b1;
      out_char_nxt    = CHAR_MINUS;
      out_last_nxt    = 1'b0;
      neg_pending_nxt = 1'b0;
    end
  end

  itoa_chain #(
    .NCELL (WORD_BITS)
  ) u_chain (
    .clk         (clk),
    .ctl         (ctl),
    .bit_in      (mag_r[WORD_BITS-1]),
    .radix       (radix_eff),
    .rd_idx      (idx_r),
    .rd_digit    (rd_digit),
    .digit_count (digit_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      radix_r       <= RADIX_RESET;
      out_valid_r   <= 1'b0;
      neg_pending_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      radix_r       <= radix_nxt;
      out_valid_r   <= out_valid_nxt;
      neg_pending_r <= neg_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    step_r     <= step_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule

[src/itoa_cell.sv]
// one digit cell: doubles its digit, adds the carry from below, reduces by the radix
module itoa_cell import itoa_pkg::*; (
  input  logic               clk,
  input  chain_ctl_t         ctl,
  input  logic [RADIX_W-1:0] radix,
  input  logic               carry_in,
  output logic               gen,
  output logic               prop,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   sum;
  logic               carry_out;

  always_comb begin
    dbl       = {digit_r, 1'b0};
    gen       = dbl >= {1'b0, radix};
    // 2d + 1 hits the radix exactly: carry out only if a carry comes in
    prop      = (dbl + (DIGIT_W+1)'(1)) == {1'b0, radix};
    sum       = dbl + (DIGIT_W+1)'(carry_in);
    carry_out = gen | (prop & carry_in);
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = carry_out ? DIGIT_W'(sum - {1'b0, radix}) : DIGIT_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

[src/itoa_chain.sv]
// row of digit cells with a lookahead carry path and a significant-digit count
module itoa_chain import itoa_pkg::*; #(
  parameter int NCELL = 32
) (
  input  logic                       clk,
  input  chain_ctl_t                 ctl,
  input  logic                       bit_in,
  input  logic [RADIX_W-1:0]         radix,
  input  logic [$clog2(NCELL)-1:0]   rd_idx,
  output logic [DIGIT_W-1:0]         rd_digit,
  output logic [$clog2(NCELL+1)-1:0] digit_count
);

  localparam int CW = $clog2(NCELL+1);

  logic [NCELL-1:0]   gen;
  logic [NCELL-1:0]   prop;
  logic [NCELL:0]     carry;
  logic [NCELL:0]     sum;
  logic [DIGIT_W-1:0] digits [NCELL];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;

  genvar i;
  generate
    for (i = 0; i < NCELL; i++) begin : g_cell
      itoa_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .radix    (radix),
        .carry_in (carry[i]),
        .gen      (gen[i]),
        .prop     (prop[i]),
        .digit    (digits[i])
      );
    end
  endgenerate

  // generate and propagate are exclusive, so one add resolves every carry
  always_comb begin
    sum   = {1'b0, gen} + {1'b0, gen | prop} + (NCELL+1)'(bit_in);
    carry = {sum[NCELL], sum[NCELL-1:0] ^ prop};
  end

  // doubling adds at most one digit per step
  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = CW'(1);
    end else if (ctl.shift && carry[count_r]) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign rd_digit    = digits[rd_idx];
  assign digit_count = count_r;

endmodule

[verif/tb_integer_to_radix_ascii.sv]
// testbench for integer_to_radix_ascii: predicts the digit text of each request and checks it
module tb_integer_to_radix_ascii;
  import itoa_pkg::*;

  localparam int VALUE_W = 32;
  localparam logic [2:0] RADIX_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last_char;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  text_char_t        expected_text[$];
  logic [RADIX_W-1:0] radix_shadow;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_cycles;
  int                error_count;

  integer_to_radix_ascii #(.WORD_BITS(VALUE_W)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_character(out_character), .out_last_char(out_last_char),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // appends the characters that one value turns into under the current radix
  function automatic void queue_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] d;
    logic [CHAR_W-1:0]  digits[$];
    text_char_t         item;
    if (radix_shadow < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_shadow > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_shadow;
    end
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    if (mag == '0) begin
      digits.push_front(CHAR_ZERO);
    end
    while (mag != '0) begin
      d = DIGIT_W'(mag % base);
      digits.push_front((d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d) - 7'd10);
      mag = mag / base;
    end
    if (v[VALUE_W-1]) begin
      item.ch = CHAR_MINUS;
      item.last = 1'b0;
      expected_text.push_back(item);
    end
    foreach (digits[i]) begin
      item.ch = digits[i];
      item.last = (i == digits.size() - 1);
      expected_text.push_back(item);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom_range(999);
      1: v = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
      2: v = (VALUE_W'(1) << $urandom_range(VALUE_W - 1)) - 1'b1;
      3: v = $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: v = $urandom;
    endcase
    if ($urandom_range(1) == 1) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // checker: every accepted character is matched against the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        error_count++;
        $display("%0t: unexpected character %h last %b", $time, out_character, out_last_char);
      end else begin
        want = expected_text.pop_front();
        if (want.ch !== out_character || want.last !== out_last_char) begin
          error_count++;
          $display("%0t: expected character %h last %b, got %h last %b", $time,
                   want.ch, want.last, out_character, out_last_char);
        end
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_value = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    do @(posedge clk); while (!in_ready);
    queue_text(v);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_RADIX) begin
      radix_shadow = data[RADIX_W-1:0];
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_radix_readback();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = RADIX_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[RADIX_W-1:0] !== radix_shadow) begin
      error_count++;
      $display("%0t: expected radix readback %0d, got %0d", $time,
               radix_shadow, prdata[RADIX_W-1:0]);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_radix(input logic [31:0] r);
    apb_write(RADIX_ADDR, r);
    check_radix_readback();
  endtask

  task automatic test_default_radix();
    check_radix_readback();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd7);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'd1_000_000_000);
    send_value(-32'sd1_000_000_000);
    drain_results();
  endtask

  task automatic test_radix_limits();
    set_radix(32'd2);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'd1);
    drain_results();
    set_radix(32'd36);
    send_value(32'd35);
    send_value(-32'sd36);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    drain_results();
    // out-of-range radix values saturate at both ends
    set_radix(32'd0);
    send_value(32'd6);
    drain_results();
    set_radix(32'd1);
    send_value(-32'sd5);
    drain_results();
    set_radix(32'd37);
    send_value(32'd71);
    drain_results();
    set_radix(32'd63);
    send_value(-32'sd1295);
    drain_results();
    // writes to the unused register slot leave the radix alone
    set_radix(32'd16);
    apb_write(SPARE_ADDR, 32'd8);
    check_radix_readback();
    send_value(32'hdead_beef);
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        drain_results();
        set_radix(($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(2, 36));
      end
      send_value(random_value());
    end
    drain_results();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_radix(32'd2);
    @(posedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) begin
      send_value(random_value());
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    radix_shadow = RADIX_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_radix();
    test_radix_limits();
    test_random_traffic(0, 0, 85);
    test_random_traffic(62, 0, 85);
    test_random_traffic(0, 62, 85);
    test_random_traffic(8, 8, 85);
    test_output_hold();

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_text.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
